### design/conv2d_zero_pad_relu_unit_defines.svh
// assertion macros shared by the conv2d unit modules
`ifndef CONV2D_ZERO_PAD_RELU_UNIT_DEFINES_SVH
`define CONV2D_ZERO_PAD_RELU_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define CZPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define CZPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/czpr_pkg.sv
// package: field widths, codes, defaults and shared types of the conv2d unit
package czpr_pkg;

  // fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned CHAN_W    = 16;
  localparam int unsigned MAX_CHAN  = 3;
  localparam int unsigned ACT_W     = 39;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 2 * CHAN_W;

  // clamped dimension widths, cover the full parameter ranges
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned TAP_DIM_W = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLT_H = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLT_W = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_IMG_H = 7'd64;
  localparam logic [CFG_W-1:0] RST_IMG_W = 7'd64;
  localparam logic [CFG_W-1:0] RST_FLT_H = 7'd3;
  localparam logic [CFG_W-1:0] RST_FLT_W = 7'd3;

  // parameter defaults
  localparam int unsigned DEF_MAX_ROWS      = 64;
  localparam int unsigned DEF_MAX_COLS      = 64;
  localparam int unsigned DEF_MAX_TAPS_SIDE = 5;
  localparam int unsigned DEF_CHANNELS      = 3;
  localparam int unsigned DEF_PAD           = 1;
  localparam int unsigned DEF_STEP          = 1;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_WEIGHT,
    KIND_COMPUTE
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } back_state_e;

  // one classified item waiting for the back end
  typedef struct packed {
    kind_e                        kind;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic [MAX_CHAN*CHAN_W-1:0]   data;
  } entry_t;

  // clamped dimensions in use
  typedef struct packed {
    logic [DIM_W-1:0]     img_h;
    logic [DIM_W-1:0]     img_w;
    logic [TAP_DIM_W-1:0] flt_h;
    logic [TAP_DIM_W-1:0] flt_w;
  } dims_t;

endpackage

### design/czpr_if.sv
// valid/ready channel interfaces for the item and result streams
interface czpr_in_if;
  import czpr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic signed [CHAN_W-1:0]  chan0;
  logic signed [CHAN_W-1:0]  chan1;
  logic signed [CHAN_W-1:0]  chan2;

  modport source (output valid, command, row, col, chan0, chan1, chan2, input ready);
  modport sink   (input valid, command, row, col, chan0, chan1, chan2, output ready);
endinterface

interface czpr_out_if;
  import czpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] activation;
  logic             saturated;

  modport source (output valid, activation, saturated, input ready);
  modport sink   (input valid, activation, saturated, output ready);
endinterface

### design/czpr_ram.sv
// generic single-write, single-read ram with registered read data
module czpr_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/czpr_queue.sv
// short fifo of classified items between front and back
module czpr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  czpr_pkg::entry_t  push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output czpr_pkg::entry_t  pop_entry_o
);
  import czpr_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      priority if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

`include "conv2d_zero_pad_relu_unit_defines.svh"

  `CZPR_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt_q) <= QUEUE_DEPTH, "queue fill count overflow")
  `CZPR_ASSERT_NEXT(a_pop_only_drops, pop && !push, cnt_q == $past(cnt_q) - CW'(1), "pop lost count")
  `CZPR_ASSERT_NOW(a_ptr_match, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue pointers differ")

endmodule

### design/czpr_front.sv
// front end: configuration registers, item acceptance and classification
module czpr_front #(
  parameter int unsigned MAX_ROWS      = czpr_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS      = czpr_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_TAPS_SIDE = czpr_pkg::DEF_MAX_TAPS_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [czpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [czpr_pkg::CFG_W-1:0]      cfg_data_i,
  czpr_in_if.sink                         in_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output czpr_pkg::entry_t                push_entry_o,
  output czpr_pkg::dims_t                 dims_o
);
  import czpr_pkg::*;

  logic [CFG_W-1:0] img_h_q, img_w_q, flt_h_q, flt_w_q;
  logic             keep;
  kind_e            kind;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q <= RST_IMG_H;
      img_w_q <= RST_IMG_W;
      flt_h_q <= RST_FLT_H;
      flt_w_q <= RST_FLT_W;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMG_H: img_h_q <= cfg_data_i;
        CFG_IMG_W: img_w_q <= cfg_data_i;
        CFG_FLT_H: flt_h_q <= {4'd0, cfg_data_i[2:0]};
        CFG_FLT_W: flt_w_q <= {4'd0, cfg_data_i[2:0]};
        default:   img_h_q <= img_h_q;
      endcase
    end
  end

  // clamp each dimension into 1 .. store size
  always_comb begin
    if (img_h_q == '0)                   dims_o.img_h = DIM_W'(1);
    else if (32'(img_h_q) > MAX_ROWS)    dims_o.img_h = DIM_W'(MAX_ROWS);
    else                                 dims_o.img_h = DIM_W'(img_h_q);
    if (img_w_q == '0)                   dims_o.img_w = DIM_W'(1);
    else if (32'(img_w_q) > MAX_COLS)    dims_o.img_w = DIM_W'(MAX_COLS);
    else                                 dims_o.img_w = DIM_W'(img_w_q);
    if (flt_h_q == '0)                   dims_o.flt_h = TAP_DIM_W'(1);
    else if (32'(flt_h_q) > MAX_TAPS_SIDE) dims_o.flt_h = TAP_DIM_W'(MAX_TAPS_SIDE);
    else                                 dims_o.flt_h = TAP_DIM_W'(flt_h_q);
    if (flt_w_q == '0)                   dims_o.flt_w = TAP_DIM_W'(1);
    else if (32'(flt_w_q) > MAX_TAPS_SIDE) dims_o.flt_w = TAP_DIM_W'(MAX_TAPS_SIDE);
    else                                 dims_o.flt_w = TAP_DIM_W'(flt_w_q);
  end

  // classify: writes outside their store and unknown commands are dropped
  always_comb begin
    kind = KIND_COMPUTE;
    keep = 1'b0;
    unique case (in_i.command)
      CMD_PIXEL: begin
        kind = KIND_PIXEL;
        keep = (32'(in_i.row) < MAX_ROWS) && (32'(in_i.col) < MAX_COLS);
      end
      CMD_WEIGHT: begin
        kind = KIND_WEIGHT;
        keep = (32'(in_i.row) < MAX_TAPS_SIDE) && (32'(in_i.col) < MAX_TAPS_SIDE);
      end
      CMD_COMPUTE: begin
        kind = KIND_COMPUTE;
        keep = 1'b1;
      end
      default: begin
        kind = KIND_COMPUTE;
        keep = 1'b0;
      end
    endcase
  end

  // a dropped beat is taken whenever the queue could take one
  assign in_i.ready         = push_ready_i;
  assign push_valid_o       = in_i.valid && keep;
  assign push_entry_o.kind  = kind;
  assign push_entry_o.row   = in_i.row;
  assign push_entry_o.col   = in_i.col;
  assign push_entry_o.data  = {in_i.chan2, in_i.chan1, in_i.chan0};

endmodule

### design/czpr_back.sv
// back end: store writes and the tap walk with multiply-accumulate
module czpr_back #(
  parameter int unsigned MAX_ROWS      = czpr_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS      = czpr_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_TAPS_SIDE = czpr_pkg::DEF_MAX_TAPS_SIDE,
  parameter int unsigned CHANNELS      = czpr_pkg::DEF_CHANNELS,
  parameter int unsigned PAD           = czpr_pkg::DEF_PAD,
  parameter int unsigned STEP          = czpr_pkg::DEF_STEP
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  czpr_pkg::entry_t  q_entry_i,
  input  czpr_pkg::dims_t   dims_i,
  czpr_out_if.source        out_o
);
  import czpr_pkg::*;

  localparam int unsigned PIX_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned WGT_DEPTH = MAX_TAPS_SIDE * MAX_TAPS_SIDE;
  localparam int unsigned PA_W  = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int unsigned WA_W  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int unsigned TW    = (MAX_TAPS_SIDE > 1) ? $clog2(MAX_TAPS_SIDE) : 1;
  localparam int unsigned DW    = CHANNELS * CHAN_W;
  localparam int unsigned CRD_MAX = ((1 << COORD_W) - 1) * STEP + MAX_TAPS_SIDE;
  localparam int unsigned CRD_W = $clog2(CRD_MAX + PAD + 1) + 1;
  localparam int unsigned PS_W  = PROD_W + $clog2(CHANNELS) + 1;
  localparam int unsigned ACC_RAW = PROD_W + $clog2(WGT_DEPTH * CHANNELS) + 2;
  localparam int unsigned ACC_W = (ACC_RAW > ACT_W + 1) ? ACC_RAW : ACT_W + 1;
  localparam logic signed [ACC_W-1:0] ACT_MAX_S =
    {{(ACC_W - ACT_W){1'b0}}, {ACT_W{1'b1}}};

  back_state_e state_q, state_d;

  logic [COORD_W-1:0]        row_q, col_q;
  logic [TW-1:0]             tap_i_q, tap_j_q;
  logic                      last_col, last_tap;
  logic                      q_pop, start, issue, emit, pipe_busy;
  logic                      pix_we, wgt_we;
  logic signed [CRD_W-1:0]   y_s, x_s;
  logic                      tap_en;
  logic [PA_W-1:0]           pix_waddr, pix_raddr;
  logic [WA_W-1:0]           wgt_waddr, wgt_raddr;
  logic [DW-1:0]             pix_rdata, wgt_rdata;

  // pipeline: read issued, products, channel sum
  logic                      v1_q, en1_q, v2_q, v3_q;
  logic signed [PROD_W-1:0]  prod_q [CHANNELS];
  logic signed [PROD_W-1:0]  prod_d [CHANNELS];
  logic signed [PS_W-1:0]    psum_q, psum_d;
  logic signed [ACC_W-1:0]   acc_q;

  // result register
  logic                      out_valid_q, sat_q;
  logic [ACT_W-1:0]          act_q;

  // tap position inside the image, with padding
  assign y_s = CRD_W'(int'(row_q) * STEP + int'(tap_i_q) - PAD);
  assign x_s = CRD_W'(int'(col_q) * STEP + int'(tap_j_q) - PAD);
  assign tap_en = (y_s >= 0) && (int'(y_s) < int'(dims_i.img_h)) &&
                  (x_s >= 0) && (int'(x_s) < int'(dims_i.img_w));

  assign last_col = (int'(tap_j_q) == int'(dims_i.flt_w) - 1);
  assign last_tap = last_col && (int'(tap_i_q) == int'(dims_i.flt_h) - 1);
  assign pipe_busy = v1_q || v2_q || v3_q;

  // store addresses
  assign pix_waddr = PA_W'(int'(q_entry_i.row) * MAX_COLS + int'(q_entry_i.col));
  assign wgt_waddr = WA_W'(int'(q_entry_i.row) * MAX_TAPS_SIDE + int'(q_entry_i.col));
  assign pix_raddr = PA_W'(int'(y_s) * MAX_COLS + int'(x_s));
  assign wgt_raddr = WA_W'(int'(tap_i_q) * MAX_TAPS_SIDE + int'(tap_j_q));

  czpr_ram #(
    .WIDTH (DW),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (q_entry_i.data[DW-1:0]),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  czpr_ram #(
    .WIDTH (DW),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_waddr),
    .wdata_i (q_entry_i.data[DW-1:0]),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_valid_i && q_entry_i.kind == KIND_COMPUTE) state_d = ST_RUN;
      ST_RUN:   if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN: if (!pipe_busy) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop  = (state_q == ST_IDLE) && q_valid_i;
    pix_we = q_pop && (q_entry_i.kind == KIND_PIXEL);
    wgt_we = q_pop && (q_entry_i.kind == KIND_WEIGHT);
    start  = q_pop && (q_entry_i.kind == KIND_COMPUTE);
    issue  = (state_q == ST_RUN);
    emit   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  end

  assign q_pop_o = q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // coordinate latch and tap counters
  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q   <= q_entry_i.row;
      col_q   <= q_entry_i.col;
      tap_i_q <= '0;
      tap_j_q <= '0;
    end else if (issue) begin
      if (last_col) begin
        tap_j_q <= '0;
        tap_i_q <= tap_i_q + TW'(1);
      end else begin
        tap_j_q <= tap_j_q + TW'(1);
      end
    end
  end

  // channel products, zero for taps in the padding
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      prod_d[k] = '0;
      if (en1_q) begin
        prod_d[k] = $signed(pix_rdata[k*CHAN_W +: CHAN_W]) *
                    $signed(wgt_rdata[k*CHAN_W +: CHAN_W]);
      end
    end
  end

  // sum over channels
  always_comb begin
    psum_d = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      psum_d = psum_d + PS_W'(prod_q[k]);
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // pipeline data and accumulator
  always_ff @(posedge clk_i) begin
    en1_q <= tap_en;
    if (v1_q) begin
      prod_q <= prod_d;
    end
    if (v2_q) begin
      psum_q <= psum_d;
    end
    if (start) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(psum_q);
    end
  end

  // result register: relu and saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      priority if (acc_q <= 0) begin
        act_q <= '0;
        sat_q <= 1'b0;
      end else if (acc_q > ACT_MAX_S) begin
        act_q <= '1;
        sat_q <= 1'b1;
      end else begin
        act_q <= acc_q[ACT_W-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.activation = act_q;
  assign out_o.saturated  = sat_q;

`include "conv2d_zero_pad_relu_unit_defines.svh"

  `CZPR_ASSERT_NOW(a_pipe_in_compute, v1_q, state_q == ST_RUN || state_q == ST_DRAIN, "tap beat outside a compute")
  `CZPR_ASSERT_NOW(a_done_drained, state_q == ST_DONE, !pipe_busy, "result taken before pipeline drained")
  `CZPR_ASSERT_NOW(a_pop_idle, q_pop, state_q == ST_IDLE, "queue popped while busy")
  `CZPR_ASSERT_NOW(a_sat_all_ones, out_valid_q && sat_q, act_q == '1, "saturated result not at full scale")
  `CZPR_ASSERT_NEXT(a_emit_valid, emit, out_valid_q && state_q == ST_IDLE, "emitted result not presented")

endmodule

### design/conv2d_zero_pad_relu_unit.sv
// Multi-channel 2-D convolution point unit with zero padding, ReLU and saturation.
// Item channel in_i (valid/ready): command 0 writes one pixel (row, col, chan0..2),
// command 1 writes one filter tap, command 2 asks for the output at (row, col);
// command 3 and writes outside their store are taken and dropped.
// Result channel out_o (valid/ready): one beat per compute, activation and saturated.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (image height,
// image width, filter height, filter width); write only while the unit is idle.
// A front end takes items into a two-entry queue; the back end drains it in order.
// Store writes stream at one beat per cycle while the back end is idle.
// A compute walks the filter one tap per cycle (one pixel and one weight ram read,
// CHANNELS multipliers), then drains the read, product and channel-sum stages into the
// accumulator and hands its result over; the back end takes no new item meanwhile.
// The tap walk goes through the single-read-port rams.
// Reset: registers return to 64, 64, 3, 3 and the queue empties; the stores keep
// no reset value and must be written before they are read.
// A stalled receiver holds the result in the output register; the back end keeps
// taking writes and starts the next compute, and waits only to hand over its result.
module conv2d_zero_pad_relu_unit #(
  parameter int unsigned MAX_ROWS      = czpr_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS      = czpr_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_TAPS_SIDE = czpr_pkg::DEF_MAX_TAPS_SIDE,
  parameter int unsigned CHANNELS      = czpr_pkg::DEF_CHANNELS,
  parameter int unsigned PAD           = czpr_pkg::DEF_PAD,
  parameter int unsigned STEP          = czpr_pkg::DEF_STEP
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [czpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [czpr_pkg::CFG_W-1:0]      cfg_data_i,
  czpr_in_if.sink                         in_i,
  czpr_out_if.source                      out_o
);
  import czpr_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready;
  entry_t  push_entry, pop_entry;
  dims_t   dims;

  // front: registers and classification
  czpr_front #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .MAX_TAPS_SIDE (MAX_TAPS_SIDE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry),
    .dims_o       (dims)
  );

  // queue between front and back
  czpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // back: stores and multiply-accumulate
  czpr_back #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .MAX_TAPS_SIDE (MAX_TAPS_SIDE),
    .CHANNELS      (CHANNELS),
    .PAD           (PAD),
    .STEP          (STEP)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_pop_o   (pop_ready),
    .q_entry_i (pop_entry),
    .dims_i    (dims),
    .out_o     (out_o)
  );

endmodule

### sim/tb_conv2d_zero_pad_relu_unit.sv
// testbench for the conv2d zero-pad relu unit: directed table, then random beats checked
`timescale 1ns / 1ps

module tb_conv2d_zero_pad_relu_unit;
  import czpr_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RST_CYCLES   = 9;
  localparam int ROWS         = DEF_MAX_ROWS;
  localparam int COLS         = DEF_MAX_COLS;
  localparam int TAPS         = DEF_MAX_TAPS_SIDE;
  localparam int PAD_N        = DEF_PAD;
  localparam int STEP_N       = DEF_STEP;
  localparam int COORD_TOP    = (1 << COORD_W) - 1;
  localparam int PHASE_ITEMS  = 180;
  localparam int N_SETTINGS   = 9;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int SHOW_LIMIT   = 10;
  localparam longint ACT_TOP  = (64'sd1 <<< ACT_W) - 1;

  // command code that the unit takes and drops
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  c0;
    logic [CHAN_W-1:0]  c1;
    logic [CHAN_W-1:0]  c2;
  } item_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             sat;
  } res_t;

  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IMG_H;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  czpr_in_if  in_if ();
  czpr_out_if out_if ();

  conv2d_zero_pad_relu_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // shadow of the unit: registers and both stores
  logic [CFG_W-1:0]         reg_ih, reg_iw;
  logic [2:0]               reg_fh, reg_fw;
  logic signed [CHAN_W-1:0] pix_mem [ROWS*COLS][3];
  logic signed [CHAN_W-1:0] tap_mem [TAPS*TAPS][3];
  bit                       pix_seen [ROWS*COLS];
  bit                       tap_seen [TAPS*TAPS];

  res_t     act_due_q [$];
  dir_row_t dir_tab [$];

  int  errors, n_pix, n_tap, n_cmp, n_dropped, n_results, n_positive;
  bit  calm = 1'b0;
  bit  want_hold = 1'b0;
  bit  hold_asked, hold_seen;

  // register values per setting; the first row is the reset state
  logic [CFG_W-1:0] reg_plan [N_SETTINGS][4] = '{
    '{7'd64,  7'd64, 7'd3,  7'd3},
    '{7'd0,   7'd0,  7'd0,  7'd0},
    '{7'd127, 7'd65, 7'd7,  7'd6},
    '{7'd5,   7'd7,  7'd2,  7'd4},
    '{7'd64,  7'd1,  7'd5,  7'd1},
    '{7'd1,   7'd64, 7'd8,  7'd5},
    '{7'd3,   7'd3,  7'd5,  7'd5},
    '{7'd12,  7'd9,  7'd3,  7'd13},
    '{7'd64,  7'd64, 7'd3,  7'd3}
  };

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= SHOW_LIMIT) $display("%s", msg);
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic dims_t live_dims();
    dims_t d;
    d.img_h = DIM_W'(clamp_dim(int'(reg_ih), ROWS));
    d.img_w = DIM_W'(clamp_dim(int'(reg_iw), COLS));
    d.flt_h = TAP_DIM_W'(clamp_dim(int'(reg_fh), TAPS));
    d.flt_w = TAP_DIM_W'(clamp_dim(int'(reg_fw), TAPS));
    return d;
  endfunction

  // one output point: padded window sum over taps and channels, relu, saturate
  function automatic res_t conv_point(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    dims_t  d;
    longint acc;
    int     y, x;
    res_t   res;
    d = live_dims();
    acc = 0;
    for (int i = 0; i < int'(d.flt_h); i++) begin
      y = int'(r) * STEP_N + i - PAD_N;
      if (y >= 0 && y < int'(d.img_h)) begin
        for (int j = 0; j < int'(d.flt_w); j++) begin
          x = int'(c) * STEP_N + j - PAD_N;
          if (x >= 0 && x < int'(d.img_w)) begin
            for (int k = 0; k < 3; k++)
              acc += longint'(pix_mem[y*COLS + x][k]) * longint'(tap_mem[i*TAPS + j][k]);
          end
        end
      end
    end
    if (acc <= 0) begin
      res = '0;
    end else if (acc > ACT_TOP) begin
      res.act = ACT_TOP[ACT_W-1:0];
      res.sat = 1'b1;
    end else begin
      res.act = acc[ACT_W-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // fold an accepted beat into the shadow, queue what a compute should return
  function automatic void absorb(input item_t it, input bit typed, input res_t want);
    int at;
    case (it.cmd)
      CMD_PIXEL: begin
        at = int'(it.row) * COLS + int'(it.col);
        pix_mem[at][0] = it.c0;
        pix_mem[at][1] = it.c1;
        pix_mem[at][2] = it.c2;
        pix_seen[at] = 1'b1;
        n_pix++;
      end
      CMD_WEIGHT: begin
        if (int'(it.row) < TAPS && int'(it.col) < TAPS) begin
          at = int'(it.row) * TAPS + int'(it.col);
          tap_mem[at][0] = it.c0;
          tap_mem[at][1] = it.c1;
          tap_mem[at][2] = it.c2;
          tap_seen[at] = 1'b1;
          n_tap++;
        end else begin
          n_dropped++;
        end
      end
      CMD_COMPUTE: begin
        act_due_q.push_back(typed ? want : conv_point(it.row, it.col));
        n_cmp++;
      end
      default: n_dropped++;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic item_t mk(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] r,
                               input logic [COORD_W-1:0] c);
    item_t it;
    it.cmd = cmd;
    it.row = r;
    it.col = c;
    it.c0  = rand_chan();
    it.c1  = rand_chan();
    it.c2  = rand_chan();
    return it;
  endfunction

  function automatic void drow(input logic [CMD_W-1:0] cmd, input int r, input int c,
                               input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                               input logic [CHAN_W-1:0] c2, input bit typed,
                               input logic [ACT_W-1:0] act);
    dir_row_t d;
    d.it    = '{cmd, COORD_W'(r), COORD_W'(c), c0, c1, c2};
    d.typed = typed;
    d.want  = '{act, 1'b0};
    dir_tab.push_back(d);
  endfunction

  // directed rows; compute (0,0) with a 3x3 filter pairs pixel (y,x) with tap (y+1,x+1)
  task automatic load_table();
    drow(CMD_WEIGHT,  1,  1, 16'h7FFF, 16'h8000, 16'h0001, 0, '0);
    drow(CMD_WEIGHT,  1,  2, 16'h0000, 16'h0000, 16'h0000, 0, '0);
    drow(CMD_WEIGHT,  2,  1, 16'h0000, 16'h0000, 16'h0000, 0, '0);
    drow(CMD_WEIGHT,  2,  2, 16'h0000, 16'h0000, 16'h0000, 0, '0);
    drow(CMD_PIXEL,   0,  0, 16'h7FFF, 16'h8000, 16'h0000, 0, '0);
    drow(CMD_PIXEL,   0,  1, 16'h8000, 16'h8000, 16'h8000, 0, '0);
    drow(CMD_PIXEL,   1,  0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0);
    drow(CMD_PIXEL,   1,  1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
    // both extreme products add up
    drow(CMD_COMPUTE, 0,  0, 16'h0000, 16'h0000, 16'h0000, 1, 39'd2147418113);
    // tap writes outside the filter store, one would alias tap (1,1) if folded
    drow(CMD_WEIGHT,  0,  6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
    drow(CMD_WEIGHT,  5,  5, 16'h1234, 16'h1234, 16'h1234, 0, '0);
    drow(CMD_WEIGHT, 63, 63, 16'h8000, 16'h8000, 16'h8000, 0, '0);
    // unknown command aimed at a live pixel
    drow(CMD_NONE,    0,  0, 16'h0000, 16'h0000, 16'h0000, 0, '0);
    drow(CMD_COMPUTE, 0,  0, 16'h0000, 16'h0000, 16'h0000, 1, 39'd2147418113);
    // negative sum clips to zero
    drow(CMD_PIXEL,   0,  0, 16'h8000, 16'h7FFF, 16'h0000, 0, '0);
    drow(CMD_COMPUTE, 0,  0, 16'h0000, 16'h0000, 16'h0000, 1, '0);
    // small positive sum
    drow(CMD_WEIGHT,  2,  2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
    drow(CMD_PIXEL,   0,  0, 16'h0000, 16'h0000, 16'h0000, 0, '0);
    drow(CMD_COMPUTE, 0,  0, 16'h0000, 16'h0000, 16'h0000, 1, 39'd3);
    // far corners of the store
    drow(CMD_PIXEL,  63, 63, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0);
    drow(CMD_PIXEL,  63,  0, 16'h8000, 16'h0000, 16'h7FFF, 0, '0);
    drow(CMD_NONE,   63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
    drow(CMD_WEIGHT,  4,  4, 16'h7FFF, 16'h8000, 16'hFFFF, 0, '0);
  endtask

  // drive one beat, wait for the handshake, maybe leave a gap afterwards
  task automatic offer(input item_t it, input bit typed, input res_t want);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.command <= it.cmd;
    in_if.row     <= it.row;
    in_if.col     <= it.col;
    in_if.chan0   <= it.c0;
    in_if.chan1   <= it.c1;
    in_if.chan2   <= it.c2;
    do @(posedge clk_i); while (!in_if.ready);
    absorb(it, typed, want);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // compute at (r,c), writing first any pixel or tap of its window not yet written
  task automatic run_compute(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    dims_t d;
    int    y, x;
    d = live_dims();
    for (int i = 0; i < int'(d.flt_h); i++) begin
      y = int'(r) * STEP_N + i - PAD_N;
      if (y >= 0 && y < int'(d.img_h)) begin
        for (int j = 0; j < int'(d.flt_w); j++) begin
          x = int'(c) * STEP_N + j - PAD_N;
          if (x >= 0 && x < int'(d.img_w)) begin
            if (!tap_seen[i*TAPS + j])
              offer(mk(CMD_WEIGHT, COORD_W'(i), COORD_W'(j)), 1'b0, '0);
            if (!pix_seen[y*COLS + x])
              offer(mk(CMD_PIXEL, COORD_W'(y), COORD_W'(x)), 1'b0, '0);
          end
        end
      end
    end
    offer(mk(CMD_COMPUTE, r, c), 1'b0, '0);
  endtask

  task automatic random_phase(input int quota, input bit with_hold);
    int    base, pick;
    dims_t d;
    logic [COORD_W-1:0] r, c;
    base = n_pix + n_tap + n_cmp;
    while (n_pix + n_tap + n_cmp - base < quota) begin
      if (with_hold && !hold_asked && n_pix + n_tap + n_cmp - base >= HOLD_AFTER) begin
        want_hold  <= 1'b1;
        hold_asked = 1'b1;
      end
      d = live_dims();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: dropped commands and taps outside the filter store
        case ($urandom_range(0, 2))
          0: offer(mk(CMD_NONE, COORD_W'($urandom), COORD_W'($urandom)), 1'b0, '0);
          1: offer(mk(CMD_WEIGHT, COORD_W'($urandom_range(TAPS, COORD_TOP)),
                      COORD_W'($urandom)), 1'b0, '0);
          default:
            offer(mk(CMD_WEIGHT, COORD_W'($urandom),
                     COORD_W'($urandom_range(TAPS, COORD_TOP))), 1'b0, '0);
        endcase
      end else if (pick < 55) begin
        if ($urandom_range(0, 3) != 0) begin
          r = COORD_W'($urandom_range(0, (int'(d.img_h) < ROWS) ? int'(d.img_h) : ROWS - 1));
          c = COORD_W'($urandom_range(0, (int'(d.img_w) < COLS) ? int'(d.img_w) : COLS - 1));
        end else begin
          r = COORD_W'($urandom);
          c = COORD_W'($urandom);
        end
        run_compute(r, c);
      end else if (pick < 75) begin
        offer(mk(CMD_WEIGHT, COORD_W'($urandom_range(0, TAPS - 1)),
                 COORD_W'($urandom_range(0, TAPS - 1))), 1'b0, '0);
      end else if ($urandom_range(0, 3) != 0) begin
        offer(mk(CMD_PIXEL, COORD_W'($urandom_range(0, int'(d.img_h) - 1)),
                 COORD_W'($urandom_range(0, int'(d.img_w) - 1))), 1'b0, '0);
      end else begin
        offer(mk(CMD_PIXEL, COORD_W'($urandom), COORD_W'($urandom)), 1'b0, '0);
      end
    end
  endtask

  // drop valid, wait for every pending result, then let the back end finish writes
  task automatic settle();
    in_if.valid <= 1'b0;
    while (act_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_IMG_H: reg_ih = val;
      CFG_IMG_W: reg_iw = val;
      CFG_FLT_H: reg_fh = val[2:0];
      CFG_FLT_W: reg_fw = val[2:0];
      default: ;
    endcase
  endtask

  // result side: compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (out_if.activation != '0) n_positive++;
      if (act_due_q.size() == 0) begin
        flag_error($sformatf("result beat %0d with nothing pending: activation %0d sat %0b",
                             n_results, out_if.activation, out_if.saturated));
      end else begin
        want = act_due_q.pop_front();
        if (out_if.activation !== want.act || out_if.saturated !== want.sat)
          flag_error($sformatf("result beat %0d: activation exp %0d got %0d, sat exp %0b got %0b",
                               n_results, want.act, out_if.activation, want.sat,
                               out_if.saturated));
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (want_hold && !hold_seen) begin
        hold_seen  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    in_if.valid   = 1'b0;
    in_if.command = CMD_PIXEL;
    in_if.row     = '0;
    in_if.col     = '0;
    in_if.chan0   = '0;
    in_if.chan1   = '0;
    in_if.chan2   = '0;
    reg_ih = RST_IMG_H;
    reg_iw = RST_IMG_W;
    reg_fh = RST_FLT_H[2:0];
    reg_fw = RST_FLT_W[2:0];
    load_table();
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) offer(dir_tab[n].it, dir_tab[n].typed, dir_tab[n].want);
    random_phase(PHASE_ITEMS, 1'b0);

    for (int p = 1; p < N_SETTINGS; p++) begin
      settle();
      if (p == N_SETTINGS - 1) calm <= 1'b1;
      cfg_beat(CFG_IMG_H, reg_plan[p][0]);
      cfg_beat(CFG_IMG_W, reg_plan[p][1]);
      cfg_beat(CFG_FLT_H, reg_plan[p][2]);
      cfg_beat(CFG_FLT_W, reg_plan[p][3]);
      cfg_we_i <= 1'b0;
      random_phase(PHASE_ITEMS, p == 2);
    end
    settle();

    if (act_due_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", act_due_q.size()));
    $display("covered %0d settings: %0d pixel, %0d tap, %0d compute beats, %0d dropped",
             N_SETTINGS, n_pix, n_tap, n_cmp, n_dropped);
    $display("checked %0d results (%0d non-zero), long output hold %s, %0d errors",
             n_results, n_positive, hold_seen ? "applied" : "not applied", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
